>>> hdl/cfc_pkg.sv
package cfc_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int TIMER_BITS_DEF  = 16;

   localparam int THR_BITS    = 16;
   localparam int SETTLE_BITS = 16;
   localparam int Q_FRAC_BITS = 16;

   localparam int APB_ADDR_BITS = 5;
   localparam int APB_DATA_BITS = 32;

   // register indexes, byte address is 4 * index
   localparam logic [2:0] REG_THR_ACTIVE     = 3'd0;
   localparam logic [2:0] REG_THR_DISCONNECT = 3'd1;
   localparam logic [2:0] REG_THR_FUSE       = 3'd2;
   localparam logic [2:0] REG_SETTLE_MS      = 3'd3;
   localparam logic [2:0] REG_MONITOR_ENABLE = 3'd4;

   // midpoints of 0, 1/93.8, 1/70.6 and 1/47.4 in Q0.16, truncated
   localparam logic [THR_BITS-1:0]    THR_ACTIVE_RST     = 16'd349;
   localparam logic [THR_BITS-1:0]    THR_DISCONNECT_RST = 16'd813;
   localparam logic [THR_BITS-1:0]    THR_FUSE_RST       = 16'd1155;
   localparam logic [SETTLE_BITS-1:0] SETTLE_MS_RST      = 16'd100;

   localparam logic [1:0] CLS_ACTIVE       = 2'd0;
   localparam logic [1:0] CLS_DISCONNECTED = 2'd1;
   localparam logic [1:0] CLS_FUSE         = 2'd2;
   localparam logic [1:0] CLS_NORMAL       = 2'd3;

   localparam logic MODE_TICK   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef struct packed {
      logic [THR_BITS-1:0]    thr_active;
      logic [THR_BITS-1:0]    thr_disconnect;
      logic [THR_BITS-1:0]    thr_fuse;
      logic [SETTLE_BITS-1:0] settle_ms;
      logic                   monitor_enable;
   } cfg_type;

   typedef struct packed {
      logic [1:0] code;
      logic       active;
      logic       normal;
      logic       warn;
      logic       err;
   } status_type;

endpackage

>>> hdl/cfc_csr.sv
module cfc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cfc_pkg::APB_ADDR_BITS-1:0]   paddr,
   input  logic [cfc_pkg::APB_DATA_BITS-1:0]   pwdata,
   output logic [cfc_pkg::APB_DATA_BITS-1:0]   prdata,
   output logic                                pready,
   output cfc_pkg::cfg_type                    cfg
);
   import cfc_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign reg_index = paddr[APB_ADDR_BITS-1:2];
   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_THR_ACTIVE:     cfg_in.thr_active     = pwdata[THR_BITS-1:0];
            REG_THR_DISCONNECT: cfg_in.thr_disconnect = pwdata[THR_BITS-1:0];
            REG_THR_FUSE:       cfg_in.thr_fuse       = pwdata[THR_BITS-1:0];
            REG_SETTLE_MS:      cfg_in.settle_ms      = pwdata[SETTLE_BITS-1:0];
            REG_MONITOR_ENABLE: cfg_in.monitor_enable = pwdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_THR_ACTIVE:     prdata = APB_DATA_BITS'(cfg_ff.thr_active);
         REG_THR_DISCONNECT: prdata = APB_DATA_BITS'(cfg_ff.thr_disconnect);
         REG_THR_FUSE:       prdata = APB_DATA_BITS'(cfg_ff.thr_fuse);
         REG_SETTLE_MS:      prdata = APB_DATA_BITS'(cfg_ff.settle_ms);
         REG_MONITOR_ENABLE: prdata = APB_DATA_BITS'(cfg_ff.monitor_enable);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thr_active     <= THR_ACTIVE_RST;
         cfg_ff.thr_disconnect <= THR_DISCONNECT_RST;
         cfg_ff.thr_fuse       <= THR_FUSE_RST;
         cfg_ff.settle_ms      <= SETTLE_MS_RST;
         cfg_ff.monitor_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/cfc_classify.sv
module cfc_classify #(
   parameter int SAMPLE_BITS = cfc_pkg::SAMPLE_BITS_DEF
) (
   input  logic [SAMPLE_BITS-1:0] supply,
   input  logic [SAMPLE_BITS-1:0] clamp,
   input  cfc_pkg::cfg_type       cfg,
   output logic [1:0]             cls
);
   import cfc_pkg::*;

   localparam int PW = SAMPLE_BITS + Q_FRAC_BITS;

   logic [PW-1:0] lhs;
   logic [PW-1:0] prod_active;
   logic [PW-1:0] prod_disconnect;
   logic [PW-1:0] prod_fuse;

   // clamp * 2^16 against supply * ratio, three products side by side
   assign lhs             = {clamp, {Q_FRAC_BITS{1'b0}}};
   assign prod_active     = PW'(supply) * PW'(cfg.thr_active);
   assign prod_disconnect = PW'(supply) * PW'(cfg.thr_disconnect);
   assign prod_fuse       = PW'(supply) * PW'(cfg.thr_fuse);

   // first comparison that holds wins, also with unordered thresholds
   always_comb begin
      priority if (lhs < prod_active) begin
         cls = CLS_ACTIVE;
      end else if (lhs < prod_disconnect) begin
         cls = CLS_DISCONNECTED;
      end else if (lhs < prod_fuse) begin
         cls = CLS_FUSE;
      end else begin
         cls = CLS_NORMAL;
      end
   end

endmodule

>>> hdl/cfc_state.sv
module cfc_state #(
   parameter int TIMER_BITS = cfc_pkg::TIMER_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic                 mode,
   input  logic [1:0]           cls,
   input  cfc_pkg::cfg_type     cfg,
   output cfc_pkg::status_type  status_next
);
   import cfc_pkg::*;

   localparam int CW = (TIMER_BITS > SETTLE_BITS) ? TIMER_BITS : SETTLE_BITS;

   status_type              status_ff;
   status_type              status_in;
   logic [TIMER_BITS-1:0]   settle_count_ff;
   logic [TIMER_BITS-1:0]   settle_count_in;
   logic [CW-1:0]           settle_wide;
   logic [CW-1:0]           timer_max_wide;
   logic [TIMER_BITS-1:0]   settle_load;
   logic                    expired;

   // saturate the reload when the counter is narrower than the register
   assign settle_wide    = CW'(cfg.settle_ms);
   assign timer_max_wide = CW'({TIMER_BITS{1'b1}});
   assign settle_load    = (settle_wide > timer_max_wide) ?
                           timer_max_wide[TIMER_BITS-1:0] : settle_wide[TIMER_BITS-1:0];

   always_comb begin
      status_in       = status_ff;
      settle_count_in = settle_count_ff;
      expired         = 1'b0;
      if (mode == MODE_TICK) begin
         if (settle_count_ff != '0) begin
            settle_count_in = settle_count_ff - 1'b1;
         end
      end else if (cfg.monitor_enable) begin
         if (cls != status_ff.code) begin
            status_in.code  = cls;
            settle_count_in = settle_load;
         end
         expired          = (settle_count_in == '0);
         status_in.active = 1'b0;
         status_in.normal = 1'b0;
         status_in.warn   = 1'b0;
         status_in.err    = 1'b0;
         unique case (cls)
            CLS_ACTIVE:       status_in.active = 1'b1;
            CLS_NORMAL:       status_in.normal = 1'b1;
            CLS_DISCONNECTED: status_in.warn   = expired;
            CLS_FUSE:         status_in.err    = expired;
            default:          status_in.normal = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff.code   <= CLS_NORMAL;
         status_ff.active <= 1'b0;
         status_ff.normal <= 1'b0;
         status_ff.warn   <= 1'b0;
         status_ff.err    <= 1'b0;
         settle_count_ff  <= '0;
      end else if (fire) begin
         status_ff       <= status_in;
         settle_count_ff <= settle_count_in;
      end
   end

   assign status_next = status_in;

endmodule

>>> hdl/clamp_fault_classifier.sv
// Clamp fault classifier. Each req beat is a 1 ms tick (mode 0) or a supply/clamp sample
// pair (mode 1), and each one yields exactly one rsp beat carrying the current class and
// the held status flags. A sample is classified against three Q0.16 ratios of the supply
// with three parallel multiply-compares, all combinational between the input register
// and the result register: throughput is one beat per clock while rsp_ready is high, and
// a taken beat passes the input register and then the result register on its way to rsp.
// Fault flags rise only once the settling count, decremented by ticks and reloaded on a
// class change, has reached zero. Registers sit on the APB port at byte addresses 0x00,
// 0x04, 0x08, 0x0C and 0x10 and should only be written while no beats are in flight.
module clamp_fault_classifier #(
   parameter int SAMPLE_BITS = cfc_pkg::SAMPLE_BITS_DEF,
   parameter int TIMER_BITS  = cfc_pkg::TIMER_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic [SAMPLE_BITS-1:0]            req_supply_sample,
   input  logic [SAMPLE_BITS-1:0]            req_clamp_sample,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_clamp_code,
   output logic                              rsp_flag_active,
   output logic                              rsp_flag_normal,
   output logic                              rsp_warn_disconnected,
   output logic                              rsp_err_fuse_blown,

   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cfc_pkg::APB_ADDR_BITS-1:0] paddr,
   input  logic [cfc_pkg::APB_DATA_BITS-1:0] pwdata,
   output logic [cfc_pkg::APB_DATA_BITS-1:0] prdata,
   output logic                              pready
);
   import cfc_pkg::*;

   cfg_type                 cfg;
   logic                    in_valid_ff;
   logic                    in_valid_in;
   logic                    mode_ff;
   logic [SAMPLE_BITS-1:0]  supply_ff;
   logic [SAMPLE_BITS-1:0]  clamp_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   status_type              rsp_status_ff;
   status_type              status_next;
   logic [1:0]              cls;
   logic                    out_open;
   logic                    fire;
   logic                    req_take;

   cfc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cfc_classify #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_classify (
      .supply (supply_ff),
      .clamp  (clamp_ff),
      .cfg    (cfg),
      .cls    (cls)
   );

   cfc_state #(
      .TIMER_BITS (TIMER_BITS)
   ) u_state (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .mode        (mode_ff),
      .cls         (cls),
      .cfg         (cfg),
      .status_next (status_next)
   );

   // result register free or being drained this cycle
   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_open;
   assign req_ready = !in_valid_ff || out_open;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff   <= req_mode;
         supply_ff <= req_supply_sample;
         clamp_ff  <= req_clamp_sample;
      end
      if (fire) begin
         rsp_status_ff <= status_next;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_clamp_code        = rsp_status_ff.code;
   assign rsp_flag_active       = rsp_status_ff.active;
   assign rsp_flag_normal       = rsp_status_ff.normal;
   assign rsp_warn_disconnected = rsp_status_ff.warn;
   assign rsp_err_fuse_blown    = rsp_status_ff.err;

endmodule
